### hw/rtl/mstd_pkg.sv
// Shared types and constants for the tick divider and dispatch queue.
`timescale 1ns / 1ps

package mstd_pkg;

    localparam int ID_W    = 3;
    localparam int MASK_W  = 8;
    localparam int LEVEL_W = 5;
    localparam int SLOT_W  = 8;
    localparam int FACT_W  = 8;

    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_ENABLE  = 2'd1,
        REQ_DISABLE = 2'd2,
        REQ_DRAIN   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_DRAIN,
        ST_DONE
    } state_t;

endpackage

### hw/rtl/mstd_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module mstd_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hw/rtl/multi_slot_tick_divider_dispatch.sv
// Tick divider over a set of slots with a FIFO of fired slot ids.
// Tick: the shared increment/compare unit visits one slot per cycle in the tick state,
// then the done state loads the output register; enable/disable go straight to done;
// drain takes the queue head by one registered RAM read in the drain state, which an empty queue skips.
// Throughput: one request at a time; a new request is taken once the previous result
// sits in the output register.
// Reset: asynchronous, clears all slots and empties the queue; no clearing pass.
`timescale 1ns / 1ps

module multi_slot_tick_divider_dispatch #(
    parameter int SLOTS       = 8,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [1:0]                    req_type,
    input  logic [mstd_pkg::SLOT_W-1:0]   slot,
    input  logic [mstd_pkg::FACT_W-1:0]   divide_factor,

    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic                          ok,
    output logic [mstd_pkg::SLOT_W-1:0]   fired_slot,
    output logic [mstd_pkg::MASK_W-1:0]   fired_mask,
    output logic                          overflow,
    output logic [mstd_pkg::LEVEL_W-1:0]  queue_level
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    mstd_pkg::state_t state_reg, state_next;

    logic                        en_reg     [SLOTS];
    logic [mstd_pkg::FACT_W-1:0] factor_reg [SLOTS];
    logic [mstd_pkg::FACT_W-1:0] count_reg  [SLOTS];

    logic [SW-1:0] cur_reg;
    logic [QW-1:0] head_reg, tail_reg;
    logic [FW-1:0] fill_reg;

    logic                        res_ok_reg;
    logic [mstd_pkg::ID_W-1:0]   res_id_reg;
    logic [mstd_pkg::MASK_W-1:0] res_mask_reg;
    logic                        res_ovf_reg;

    logic                          rsp_valid_reg;
    logic                          rsp_ok_reg;
    logic [mstd_pkg::SLOT_W-1:0]   rsp_slot_reg;
    logic [mstd_pkg::MASK_W-1:0]   rsp_mask_reg;
    logic                          rsp_ovf_reg;
    logic [mstd_pkg::LEVEL_W-1:0]  rsp_level_reg;

    logic                        req_acc;
    logic                        slot_ok;
    logic [SW-1:0]               slot_idx;
    logic [mstd_pkg::FACT_W-1:0] cnt_inc;
    logic                        fire;
    logic                        full;
    logic                        push;
    logic                        last_slot;
    logic                        done_go;
    logic                        ram_rd_en;
    logic [mstd_pkg::ID_W-1:0]   ram_rd_data;
    logic                        id_ok;
    logic [SW-1:0]               id_idx;
    logic [QW-1:0]               head_inc, tail_inc;

    assign req_stall = (state_reg != mstd_pkg::ST_IDLE);
    assign req_acc   = req_valid && !req_stall;
    assign slot_ok   = ({1'b0, slot} < 9'(SLOTS));
    assign slot_idx  = slot[SW-1:0];

    // shared increment/compare unit, one slot per cycle
    assign cnt_inc   = count_reg[cur_reg] + 8'd1;
    assign fire      = en_reg[cur_reg] && (cnt_inc >= factor_reg[cur_reg]);
    assign full      = (fill_reg == FW'(QUEUE_DEPTH));
    assign push      = (state_reg == mstd_pkg::ST_TICK) && fire && !full;
    assign last_slot = (cur_reg == SW'(SLOTS - 1));

    assign done_go   = !rsp_valid_reg || !rsp_stall;
    assign ram_rd_en = req_acc && (req_type == mstd_pkg::REQ_DRAIN);

    assign id_ok     = ({1'b0, ram_rd_data} < 4'(SLOTS));
    assign id_idx    = ram_rd_data[SW-1:0];

    assign head_inc  = (head_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc  = (tail_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;

    mstd_ram #(
        .WIDTH (mstd_pkg::ID_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .wr_en   (push),
        .wr_addr (tail_reg),
        .wr_data (3'(cur_reg)),
        .rd_en   (ram_rd_en),
        .rd_addr (head_reg),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mstd_pkg::ST_IDLE:
            begin
                if (req_acc)
                begin
                    case (req_type)
                        mstd_pkg::REQ_TICK:  state_next = mstd_pkg::ST_TICK;
                        mstd_pkg::REQ_DRAIN:
                            state_next = (fill_reg != '0) ? mstd_pkg::ST_DRAIN
                                                          : mstd_pkg::ST_DONE;
                        default:             state_next = mstd_pkg::ST_DONE;
                    endcase
                end
            end
            mstd_pkg::ST_TICK:
            begin
                if (last_slot)
                begin
                    state_next = mstd_pkg::ST_DONE;
                end
            end
            mstd_pkg::ST_DRAIN: state_next = mstd_pkg::ST_DONE;
            mstd_pkg::ST_DONE:
            begin
                if (done_go)
                begin
                    state_next = mstd_pkg::ST_IDLE;
                end
            end
            default: state_next = mstd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mstd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // slot table and queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                en_reg[i]     <= 1'b0;
                factor_reg[i] <= '0;
                count_reg[i]  <= '0;
            end
            cur_reg  <= '0;
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            case (state_reg)
                mstd_pkg::ST_IDLE:
                begin
                    cur_reg <= '0;
                    if (req_acc && slot_ok &&
                        (req_type == mstd_pkg::REQ_ENABLE ||
                         req_type == mstd_pkg::REQ_DISABLE))
                    begin
                        en_reg[slot_idx]     <= (req_type == mstd_pkg::REQ_ENABLE);
                        factor_reg[slot_idx] <= (req_type == mstd_pkg::REQ_ENABLE) ?
                                                divide_factor : '0;
                        count_reg[slot_idx]  <= '0;
                    end
                end
                mstd_pkg::ST_TICK:
                begin
                    if (en_reg[cur_reg])
                    begin
                        count_reg[cur_reg] <= fire ? '0 : cnt_inc;
                    end
                    if (push)
                    begin
                        tail_reg <= tail_inc;
                        fill_reg <= fill_reg + 1'b1;
                    end
                    cur_reg <= cur_reg + 1'b1;
                end
                mstd_pkg::ST_DRAIN:
                begin
                    head_reg <= head_inc;
                    fill_reg <= fill_reg - 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // per-request result accumulation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ok_reg   <= 1'b0;
            res_id_reg   <= '0;
            res_mask_reg <= '0;
            res_ovf_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                mstd_pkg::ST_IDLE:
                begin
                    if (req_acc)
                    begin
                        res_ok_reg   <= slot_ok && (req_type == mstd_pkg::REQ_ENABLE ||
                                                    req_type == mstd_pkg::REQ_DISABLE);
                        res_id_reg   <= '0;
                        res_mask_reg <= '0;
                        res_ovf_reg  <= 1'b0;
                    end
                end
                mstd_pkg::ST_TICK:
                begin
                    if (fire)
                    begin
                        res_mask_reg[3'(cur_reg)] <= 1'b1;
                        if (full)
                        begin
                            res_ovf_reg <= 1'b1;
                        end
                    end
                end
                mstd_pkg::ST_DRAIN:
                begin
                    res_id_reg <= ram_rd_data;
                    res_ok_reg <= id_ok && en_reg[id_idx];
                end
                default:
                begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            rsp_ok_reg    <= 1'b0;
            rsp_slot_reg  <= '0;
            rsp_mask_reg  <= '0;
            rsp_ovf_reg   <= 1'b0;
            rsp_level_reg <= '0;
        end
        else
        begin
            if (state_reg == mstd_pkg::ST_DONE && done_go)
            begin
                rsp_valid_reg <= 1'b1;
                rsp_ok_reg    <= res_ok_reg;
                rsp_slot_reg  <= 8'(res_id_reg);
                rsp_mask_reg  <= res_mask_reg;
                rsp_ovf_reg   <= res_ovf_reg;
                rsp_level_reg <= 5'(fill_reg);
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign ok          = rsp_ok_reg;
    assign fired_slot  = rsp_slot_reg;
    assign fired_mask  = rsp_mask_reg;
    assign overflow    = rsp_ovf_reg;
    assign queue_level = rsp_level_reg;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(QUEUE_DEPTH))
        else $error("queue fill above depth");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mstd_pkg::ST_DONE && res_ovf_reg) |-> full)
        else $error("overflow flagged with room in queue");

    a_pop_only_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg < $past(fill_reg)) |-> ($past(state_reg) == mstd_pkg::ST_DRAIN))
        else $error("queue fill dropped outside drain");

    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mstd_pkg::ST_TICK) |=> req_stall)
        else $error("request taken during tick sweep");
`endif

endmodule

### verif/multi_slot_tick_divider_dispatch_tb.sv
// Testbench for the tick divider: random and directed requests checked against a scoreboard.
`timescale 1ns / 1ps

module multi_slot_tick_divider_dispatch_tb;

    localparam int NUM_SLOTS   = 8;
    localparam int QUEUE_DEPTH = 16;
    localparam int RANDOM_REQS = 150;

    typedef struct packed {
        logic                         ok;
        logic [mstd_pkg::SLOT_W-1:0]  fired_slot;
        logic [mstd_pkg::MASK_W-1:0]  fired_mask;
        logic                         overflow;
        logic [mstd_pkg::LEVEL_W-1:0] queue_level;
    } dispatch_result_t;

    class dispatch_scoreboard;
        logic                        slot_on  [NUM_SLOTS];
        logic [mstd_pkg::FACT_W-1:0] slot_div [NUM_SLOTS];
        logic [7:0]                  slot_cnt [NUM_SLOTS];
        logic [mstd_pkg::ID_W-1:0]   queued_ids[$];
        dispatch_result_t            pending_results[$];
        int unsigned                 mismatches;

        function new();
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_on[i]  = 1'b0;
                slot_div[i] = '0;
                slot_cnt[i] = '0;
            end
            mismatches = 0;
        endfunction

        task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
            $display("mismatch on %s: got %0h, expected %0h at %0t", field, got, want, $realtime);
            mismatches++;
        endtask

        function int unsigned outstanding();
            return pending_results.size();
        endfunction

        // Works out the result of one accepted request beat and advances the slot state.
        function void note_request(mstd_pkg::req_t kind, logic [mstd_pkg::SLOT_W-1:0] s,
                                   logic [mstd_pkg::FACT_W-1:0] f);
            dispatch_result_t          r;
            logic [mstd_pkg::ID_W-1:0] id;
            r = '0;
            case (kind)
                mstd_pkg::REQ_TICK:
                begin
                    for (int i = 0; i < NUM_SLOTS; i++)
                    begin
                        if (slot_on[i])
                        begin
                            slot_cnt[i] = slot_cnt[i] + 8'd1;
                            if (slot_cnt[i] >= slot_div[i])
                            begin
                                slot_cnt[i] = '0;
                                r.fired_mask[i] = 1'b1;
                                // a full queue drops the id, later slots still get visited
                                if (queued_ids.size() >= QUEUE_DEPTH)
                                    r.overflow = 1'b1;
                                else
                                    queued_ids.push_back(mstd_pkg::ID_W'(i));
                            end
                        end
                    end
                end
                mstd_pkg::REQ_ENABLE, mstd_pkg::REQ_DISABLE:
                begin
                    if (s < NUM_SLOTS)
                    begin
                        slot_on[s]  = (kind == mstd_pkg::REQ_ENABLE);
                        slot_div[s] = (kind == mstd_pkg::REQ_ENABLE) ? f : '0;
                        slot_cnt[s] = '0;
                        r.ok = 1'b1;
                    end
                end
                default:
                begin
                    if (queued_ids.size() > 0)
                    begin
                        id = queued_ids.pop_front();
                        r.fired_slot = mstd_pkg::SLOT_W'(id);
                        r.ok = slot_on[id];
                    end
                end
            endcase
            r.queue_level = mstd_pkg::LEVEL_W'(queued_ids.size());
            pending_results.push_back(r);
        endfunction

        task check_result(dispatch_result_t got);
            dispatch_result_t want;
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result beat", 32'(got), 32'd0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.ok !== want.ok)
                    report_mismatch("ok", 32'(got.ok), 32'(want.ok));
                if (got.fired_slot !== want.fired_slot)
                    report_mismatch("fired_slot", 32'(got.fired_slot), 32'(want.fired_slot));
                if (got.fired_mask !== want.fired_mask)
                    report_mismatch("fired_mask", 32'(got.fired_mask), 32'(want.fired_mask));
                if (got.overflow !== want.overflow)
                    report_mismatch("overflow", 32'(got.overflow), 32'(want.overflow));
                if (got.queue_level !== want.queue_level)
                    report_mismatch("queue_level", 32'(got.queue_level), 32'(want.queue_level));
            end
        endtask
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         req_valid;
    logic                         req_stall;
    logic [1:0]                   req_type;
    logic [mstd_pkg::SLOT_W-1:0]  slot;
    logic [mstd_pkg::FACT_W-1:0]  divide_factor;
    logic                         rsp_valid;
    logic                         rsp_stall;
    logic                         ok;
    logic [mstd_pkg::SLOT_W-1:0]  fired_slot;
    logic [mstd_pkg::MASK_W-1:0]  fired_mask;
    logic                         overflow;
    logic [mstd_pkg::LEVEL_W-1:0] queue_level;

    dispatch_scoreboard sb;
    logic               steady;

    multi_slot_tick_divider_dispatch #(
        .SLOTS       (NUM_SLOTS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req_type      (req_type),
        .slot          (slot),
        .divide_factor (divide_factor),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .ok            (ok),
        .fired_slot    (fired_slot),
        .fired_mask    (fired_mask),
        .overflow      (overflow),
        .queue_level   (queue_level)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned idle_cycles();
        return steady ? 0 : $urandom_range(0, 9);
    endfunction

    // Values read at the edge are the ones the block saw, since all drives are nonblocking.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                sb.note_request(mstd_pkg::req_t'(req_type), slot, divide_factor);
            if (rsp_valid && !rsp_stall)
                sb.check_result('{ok, fired_slot, fired_mask, overflow, queue_level});
        end
    end

    task automatic send_request(mstd_pkg::req_t kind, logic [mstd_pkg::SLOT_W-1:0] s,
                                logic [mstd_pkg::FACT_W-1:0] f);
        int unsigned gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid     <= 1'b1;
        req_type      <= kind;
        slot          <= s;
        divide_factor <= f;
        @(posedge clk);
        while (req_stall) @(posedge clk);
    endtask

    task automatic random_request(int unsigned tick_weight);
        int unsigned                 pick;
        mstd_pkg::req_t              kind;
        logic [mstd_pkg::SLOT_W-1:0] s;
        logic [mstd_pkg::FACT_W-1:0] f;
        pick = $urandom_range(0, 99);
        if (pick < tick_weight)
            kind = mstd_pkg::REQ_TICK;
        else if (pick < tick_weight + 30)
            kind = mstd_pkg::REQ_DRAIN;
        else if (pick < tick_weight + 30 + (70 - tick_weight) * 2 / 3)
            kind = mstd_pkg::REQ_ENABLE;
        else
            kind = mstd_pkg::REQ_DISABLE;
        s = ($urandom_range(0, 9) == 0) ? mstd_pkg::SLOT_W'($urandom)
                                        : mstd_pkg::SLOT_W'($urandom_range(0, 7));
        pick = $urandom_range(0, 9);
        if (pick < 6)
            f = mstd_pkg::FACT_W'($urandom_range(0, 5));
        else if (pick < 8)
            f = mstd_pkg::FACT_W'($urandom);
        else if (pick == 8)
            f = '0;
        else
            f = '1;
        send_request(kind, s, f);
    endtask

    // Result side: per beat a random hold-off, once a long one so the block backs up.
    initial
    begin
        int unsigned hold;
        int unsigned results_taken;
        results_taken = 0;
        rsp_stall <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            hold = idle_cycles();
            if (results_taken == 200)
                hold = 300;
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!(rsp_valid && !rsp_stall)) @(posedge clk);
            results_taken++;
        end
    end

    initial
    begin
        #5_000_000;
        $display("multi_slot_tick_divider_dispatch verification failed");
        $finish;
    end

    initial
    begin
        int unsigned tick_weight;
        sb = new();
        steady        = 1'b0;
        rst_n         <= 1'b0;
        req_valid     <= 1'b0;
        req_type      <= mstd_pkg::REQ_TICK;
        slot          <= '0;
        divide_factor <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty queue, range checks, factor 0/1/255, disabled ids, overflow
        send_request(mstd_pkg::REQ_DRAIN,   8'd0,   8'd0);
        send_request(mstd_pkg::REQ_TICK,    8'd0,   8'd0);
        send_request(mstd_pkg::REQ_ENABLE,  8'd0,   8'd0);
        send_request(mstd_pkg::REQ_ENABLE,  8'd1,   8'd1);
        send_request(mstd_pkg::REQ_ENABLE,  8'd7,   8'd255);
        send_request(mstd_pkg::REQ_ENABLE,  8'd8,   8'd3);
        send_request(mstd_pkg::REQ_DISABLE, 8'd255, 8'd255);
        send_request(mstd_pkg::REQ_ENABLE,  8'd128, 8'd170);
        send_request(mstd_pkg::REQ_TICK,    8'd255, 8'd255);
        send_request(mstd_pkg::REQ_TICK,    8'd0,   8'd0);
        send_request(mstd_pkg::REQ_DRAIN,   8'd0,   8'd0);
        send_request(mstd_pkg::REQ_DISABLE, 8'd1,   8'd0);
        send_request(mstd_pkg::REQ_DRAIN,   8'd0,   8'd0);
        for (int i = 2; i < 7; i++)
            send_request(mstd_pkg::REQ_ENABLE, mstd_pkg::SLOT_W'(i), 8'd0);
        send_request(mstd_pkg::REQ_TICK,    8'd0,   8'd0);
        send_request(mstd_pkg::REQ_TICK,    8'd0,   8'd0);
        send_request(mstd_pkg::REQ_TICK,    8'd0,   8'd0);
        send_request(mstd_pkg::REQ_TICK,    8'd0,   8'd0);
        send_request(mstd_pkg::REQ_DRAIN,   8'd0,   8'd0);

        // only slot 7 left at factor 255; drained ids of the others come back not ok
        for (int i = 0; i < 7; i++)
            send_request(mstd_pkg::REQ_DISABLE, mstd_pkg::SLOT_W'(i), 8'd85);
        for (int k = 0; k < 260; k++)
        begin
            send_request(mstd_pkg::REQ_TICK, mstd_pkg::SLOT_W'($urandom),
                         mstd_pkg::FACT_W'($urandom));
            if (k % 16 == 0)
                send_request(mstd_pkg::REQ_DRAIN, mstd_pkg::SLOT_W'($urandom),
                             mstd_pkg::FACT_W'($urandom));
        end

        for (int b = 0; b < RANDOM_REQS / 50; b++)
        begin
            steady      = ($urandom_range(0, 3) == 0);
            tick_weight = $urandom_range(25, 55);
            for (int n = 0; n < 50; n++)
                random_request(tick_weight);
        end
        steady = 1'b0;
        req_valid <= 1'b0;

        // the last accepted beat is noted at this edge; let the monitor see it first
        @(posedge clk);
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (NUM_SLOTS + 6) @(posedge clk);
        if (sb.mismatches == 0)
            $display("multi_slot_tick_divider_dispatch verification clean");
        else
            $display("multi_slot_tick_divider_dispatch verification failed");
        $finish;
    end

endmodule
